### src/wsq_pkg.sv
// ----------------------------------------------------------------------------
// Work-stealing queue set: shared definitions
// Field widths, default sizes, request/status codes and sequencer states.
// ----------------------------------------------------------------------------
package wsq_pkg;

   // default sizes of the queue set
   localparam int NUM_QUEUES_DEF  = 8;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int JOB_ID_BITS_DEF = 16;

   // fixed field widths on the channels
   localparam int MODE_W   = 2;
   localparam int QIDX_W   = 3;
   localparam int JOB_W    = 16;
   localparam int STATUS_W = 2;
   localparam int CNT_W    = 16;
   localparam int ACTQ_W   = 4;

   localparam logic [ACTQ_W-1:0] ACTQ_RESET  = 4'd8;
   localparam logic [CNT_W-1:0]  PENDING_MAX = '1;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH,
      MODE_ACQUIRE,
      MODE_DONE,
      MODE_NONE
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK,
      STATUS_EMPTY,
      STATUS_FULL,
      STATUS_RANGE
   } status_type;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_BACK,
      OP_FRONT
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_META,
      ST_DATA,
      ST_FIN
   } state_type;

endpackage

### src/wsq_if.sv
// ----------------------------------------------------------------------------
// Work-stealing queue set: channel interfaces
// Request, response and register-write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wsq_req_if;
   logic                       valid;
   logic                       ready;
   logic [wsq_pkg::MODE_W-1:0] mode;
   logic [wsq_pkg::QIDX_W-1:0] queue_index;
   logic [wsq_pkg::JOB_W-1:0]  job_id;

   modport source (output valid, mode, queue_index, job_id, input ready);
   modport sink   (input valid, mode, queue_index, job_id, output ready);
endinterface

interface wsq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wsq_pkg::STATUS_W-1:0] status;
   logic [wsq_pkg::JOB_W-1:0]    got_job;
   logic [wsq_pkg::QIDX_W-1:0]   from_queue;
   logic [wsq_pkg::CNT_W-1:0]    pending_jobs;

   modport source (output valid, status, got_job, from_queue, pending_jobs, input ready);
   modport sink   (input valid, status, got_job, from_queue, pending_jobs, output ready);
endinterface

interface wsq_csr_if;
   logic                       valid;
   logic                       ready;
   logic [wsq_pkg::ACTQ_W-1:0] active_queues;

   modport source (output valid, active_queues, input ready);
   modport sink   (input valid, active_queues, output ready);
endinterface

### src/wsq_ram.sv
// ----------------------------------------------------------------------------
// Work-stealing queue set: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module wsq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/wsq_alu.sv
// ----------------------------------------------------------------------------
// Work-stealing queue set: modular adder
// Add two operands below the modulus and wrap once into range.
// ----------------------------------------------------------------------------
module wsq_alu #(
   parameter int WIDTH = 5
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   input  logic [WIDTH-1:0] modulus,
   output logic [WIDTH-1:0] sum
);

   logic [WIDTH:0] raw;

   always_comb begin
      raw = {1'b0, op_a} + {1'b0, op_b};
      if (raw >= {1'b0, modulus}) begin
         sum = WIDTH'(raw - {1'b0, modulus});
      end else begin
         sum = raw[WIDTH-1:0];
      end
   end

endmodule

### src/work_stealing_queue_set_top.sv
// ----------------------------------------------------------------------------
// Work-stealing queue set
// Per-requester job deques with LIFO own-pop, circular FIFO stealing and a
// saturating count of pending jobs.
// ----------------------------------------------------------------------------
// Usage:
//   req_if  : one request per handshake: mode (push / acquire / done),
//             queue_index and job_id. Ready is high only while the sequencer
//             is idle.
//   rsp_if  : one response per request: status, got_job, from_queue and the
//             pending count after the request. A one-entry output register
//             holds it; the next request is taken while it waits.
//   csr_if  : writes active_queues (always ready); write only while idle.
// States, from one request accept to the next:
//   done, unused mode or bad index : IDLE, FIN
//   push                           : IDLE, META, FIN
//   acquire                        : IDLE, SCAN per queue tried, META, DATA,
//                                    FIN; if none found, FIN after all SCANs
//   The search examines one queue per cycle through the single modular
//   adder; the queue descriptor and job store are registered-read RAMs.
// Reset: all queues empty, pending count zero, active_queues = 8 (clamped to
//   NUM_QUEUES). Descriptor valid bits mark never-written queues as empty,
//   so no clearing pass is run. A stalled response stalls only the finish
//   step; the sequencer holds there until the output register frees.
// ----------------------------------------------------------------------------
module work_stealing_queue_set_top #(
   parameter int NUM_QUEUES  = wsq_pkg::NUM_QUEUES_DEF,
   parameter int QUEUE_DEPTH = wsq_pkg::QUEUE_DEPTH_DEF,
   parameter int JOB_ID_BITS = wsq_pkg::JOB_ID_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   wsq_req_if.sink      req_if,
   wsq_rsp_if.source    rsp_if,
   wsq_csr_if.sink      csr_if
);

   localparam int QW  = $clog2(NUM_QUEUES);
   localparam int NW  = $clog2(NUM_QUEUES + 1);
   localparam int HW  = $clog2(QUEUE_DEPTH);
   localparam int FW  = $clog2(QUEUE_DEPTH + 1);
   localparam int UW0 = (FW > NW) ? FW : NW;
   localparam int UW  = (UW0 > wsq_pkg::ACTQ_W) ? UW0 : wsq_pkg::ACTQ_W;
   localparam int IDW = (JOB_ID_BITS < wsq_pkg::JOB_W) ? JOB_ID_BITS : wsq_pkg::JOB_W;
   localparam int MW  = HW + FW;
   localparam int SD  = NUM_QUEUES * QUEUE_DEPTH;
   localparam int SAW = $clog2(SD);

   // sequencer and control state
   wsq_pkg::state_type           state_ff, state_in;
   logic [wsq_pkg::ACTQ_W-1:0]   active_ff, active_in;
   logic [wsq_pkg::CNT_W-1:0]    pending_ff, pending_in;
   logic [NUM_QUEUES-1:0]        valid_ff, valid_in;   // descriptor written
   logic [NUM_QUEUES-1:0]        busy_ff, busy_in;     // queue holds a job
   logic                         rsp_valid_ff, rsp_valid_in;

   // working registers of the current request
   wsq_pkg::op_type              op_ff, op_in;
   wsq_pkg::status_type          status_ff, status_in;
   logic [QW-1:0]                cur_q_ff, cur_q_in;
   logic [NW-1:0]                scan_cnt_ff, scan_cnt_in;
   logic [IDW-1:0]               job_ff, job_in;
   logic [HW-1:0]                head_ff, head_in;
   logic [FW-1:0]                fill_ff, fill_in;
   logic [IDW-1:0]               got_ff, got_in;
   logic [QW-1:0]                from_ff, from_in;

   // response register
   logic [wsq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [wsq_pkg::JOB_W-1:0]    rsp_got_ff, rsp_got_in;
   logic [wsq_pkg::QIDX_W-1:0]   rsp_from_ff, rsp_from_in;
   logic [wsq_pkg::CNT_W-1:0]    rsp_pend_ff, rsp_pend_in;

   logic                         req_acc;
   logic                         rsp_free;
   logic [UW-1:0]                n_live;
   logic [UW-1:0]                act_u;
   logic                         idx_bad;
   logic                         scan_last;
   wsq_pkg::mode_type            req_mode;

   logic [UW-1:0]                alu_a, alu_b, alu_m, alu_sum;

   logic                         md_rd_en, md_wr_en;
   logic [QW-1:0]                md_rd_addr;
   logic [MW-1:0]                md_wr_data, md_rd_data;
   logic [HW-1:0]                meta_head;
   logic [FW-1:0]                meta_fill;
   logic [FW-1:0]                fill_dec;

   logic                         st_wr_en, st_rd_en;
   logic [SAW-1:0]               st_addr;
   logic [IDW-1:0]               st_rd_data;

   // handshakes
   assign req_if.ready = (state_ff == wsq_pkg::ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_acc      = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_mode     = wsq_pkg::mode_type'(req_if.mode);

   // clamp active_queues into 1..NUM_QUEUES
   always_comb begin
      act_u = UW'(active_ff);
      if (act_u == '0) begin
         n_live = UW'(1);
      end else if (act_u > UW'(NUM_QUEUES)) begin
         n_live = UW'(NUM_QUEUES);
      end else begin
         n_live = act_u;
      end
   end

   assign idx_bad   = UW'(req_if.queue_index) >= n_live;
   assign scan_last = (UW'(scan_cnt_ff) + UW'(1)) == n_live;

   // descriptor read: never-written queues read as empty
   assign meta_head = valid_ff[cur_q_ff] ? md_rd_data[MW-1:FW] : '0;
   assign meta_fill = valid_ff[cur_q_ff] ? md_rd_data[FW-1:0] : '0;
   assign fill_dec  = fill_ff - FW'(1);

   // operand select for the shared modular adder
   always_comb begin
      alu_a = '0;
      alu_b = '0;
      alu_m = UW'(QUEUE_DEPTH);
      case (state_ff)
         wsq_pkg::ST_SCAN: begin
            // advance to the next queue in circular order
            alu_a = UW'(cur_q_ff);
            alu_b = UW'(1);
            alu_m = n_live;
         end
         wsq_pkg::ST_META: begin
            // slot of back (push / pop) or front (steal)
            alu_a = UW'(meta_head);
            case (op_ff)
               wsq_pkg::OP_PUSH: alu_b = UW'(meta_fill);
               wsq_pkg::OP_BACK: alu_b = UW'(FW'(meta_fill - FW'(1)));
               default:          alu_b = '0;
            endcase
         end
         wsq_pkg::ST_DATA: begin
            // head advance after a steal
            alu_a = UW'(head_ff);
            alu_b = UW'(1);
         end
         default: begin
            alu_a = '0;
         end
      endcase
   end

   wsq_alu #(
      .WIDTH   (UW)
   ) u_alu (
      .op_a    (alu_a),
      .op_b    (alu_b),
      .modulus (alu_m),
      .sum     (alu_sum)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wsq_pkg::ST_IDLE: begin
            if (req_acc) begin
               case (req_mode)
                  wsq_pkg::MODE_PUSH:    state_in = idx_bad ? wsq_pkg::ST_FIN : wsq_pkg::ST_META;
                  wsq_pkg::MODE_ACQUIRE: state_in = idx_bad ? wsq_pkg::ST_FIN : wsq_pkg::ST_SCAN;
                  default:               state_in = wsq_pkg::ST_FIN;
               endcase
            end
         end
         wsq_pkg::ST_SCAN: begin
            if (busy_ff[cur_q_ff]) begin
               state_in = wsq_pkg::ST_META;
            end else if (scan_last) begin
               state_in = wsq_pkg::ST_FIN;
            end
         end
         wsq_pkg::ST_META: begin
            state_in = (op_ff == wsq_pkg::OP_PUSH) ? wsq_pkg::ST_FIN : wsq_pkg::ST_DATA;
         end
         wsq_pkg::ST_DATA: begin
            state_in = wsq_pkg::ST_FIN;
         end
         wsq_pkg::ST_FIN: begin
            if (rsp_free) begin
               state_in = wsq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wsq_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath and memory controls
   always_comb begin
      active_in   = active_ff;
      pending_in  = pending_ff;
      valid_in    = valid_ff;
      busy_in     = busy_ff;
      op_in       = op_ff;
      status_in   = status_ff;
      cur_q_in    = cur_q_ff;
      scan_cnt_in = scan_cnt_ff;
      job_in      = job_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      got_in      = got_ff;
      from_in     = from_ff;
      md_wr_en    = 1'b0;
      md_wr_data  = {head_ff, fill_ff};
      st_wr_en    = 1'b0;
      st_rd_en    = 1'b0;

      if (csr_if.valid) begin
         active_in = csr_if.active_queues;
      end

      case (state_ff)
         wsq_pkg::ST_IDLE: begin
            if (req_acc) begin
               cur_q_in    = QW'(req_if.queue_index);
               job_in      = req_if.job_id[IDW-1:0];
               scan_cnt_in = '0;
               got_in      = '0;
               from_in     = '0;
               status_in   = wsq_pkg::STATUS_OK;
               op_in       = (req_mode == wsq_pkg::MODE_PUSH) ? wsq_pkg::OP_PUSH
                                                              : wsq_pkg::OP_BACK;
               case (req_mode)
                  wsq_pkg::MODE_PUSH, wsq_pkg::MODE_ACQUIRE: begin
                     if (idx_bad) begin
                        status_in = wsq_pkg::STATUS_RANGE;
                     end
                  end
                  wsq_pkg::MODE_DONE: begin
                     if (pending_ff != '0) begin
                        pending_in = pending_ff - wsq_pkg::CNT_W'(1);
                     end
                  end
                  default: begin
                     status_in = wsq_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         wsq_pkg::ST_SCAN: begin
            if (busy_ff[cur_q_ff]) begin
               // own queue pops the back, others are stolen from the front
               op_in = (scan_cnt_ff == '0) ? wsq_pkg::OP_BACK : wsq_pkg::OP_FRONT;
            end else if (scan_last) begin
               status_in = wsq_pkg::STATUS_EMPTY;
            end else begin
               cur_q_in    = QW'(alu_sum);
               scan_cnt_in = scan_cnt_ff + NW'(1);
            end
         end
         wsq_pkg::ST_META: begin
            head_in = meta_head;
            fill_in = meta_fill;
            if (op_ff == wsq_pkg::OP_PUSH) begin
               if (meta_fill == FW'(QUEUE_DEPTH)) begin
                  status_in = wsq_pkg::STATUS_FULL;
               end else begin
                  st_wr_en           = 1'b1;
                  md_wr_en           = 1'b1;
                  md_wr_data         = {meta_head, FW'(meta_fill + FW'(1))};
                  valid_in[cur_q_ff] = 1'b1;
                  busy_in[cur_q_ff]  = 1'b1;
                  if (pending_ff != wsq_pkg::PENDING_MAX) begin
                     pending_in = pending_ff + wsq_pkg::CNT_W'(1);
                  end
               end
            end else begin
               st_rd_en = 1'b1;
            end
         end
         wsq_pkg::ST_DATA: begin
            got_in            = st_rd_data;
            from_in           = cur_q_ff;
            md_wr_en          = 1'b1;
            busy_in[cur_q_ff] = (fill_dec != '0);
            if (op_ff == wsq_pkg::OP_FRONT) begin
               md_wr_data = {HW'(alu_sum), fill_dec};
            end else begin
               md_wr_data = {head_ff, fill_dec};
            end
         end
         default: begin
            st_rd_en = 1'b0;
         end
      endcase
   end

   // response register: drop on take, load at finish
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_got_in    = rsp_got_ff;
      rsp_from_in   = rsp_from_ff;
      rsp_pend_in   = rsp_pend_ff;
      if (state_ff == wsq_pkg::ST_FIN && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_got_in    = wsq_pkg::JOB_W'(got_ff);
         rsp_from_in   = wsq_pkg::QIDX_W'(from_ff);
         rsp_pend_in   = pending_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.got_job      = rsp_got_ff;
   assign rsp_if.from_queue   = rsp_from_ff;
   assign rsp_if.pending_jobs = rsp_pend_ff;

   // queue descriptors: {head, fill} per queue
   assign md_rd_en   = (state_ff == wsq_pkg::ST_IDLE) || (state_ff == wsq_pkg::ST_SCAN);
   assign md_rd_addr = (state_ff == wsq_pkg::ST_IDLE) ? QW'(req_if.queue_index) : cur_q_ff;

   wsq_ram #(
      .WIDTH   (MW),
      .DEPTH   (NUM_QUEUES)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (md_wr_en),
      .wr_addr (cur_q_ff),
      .wr_data (md_wr_data),
      .rd_en   (md_rd_en),
      .rd_addr (md_rd_addr),
      .rd_data (md_rd_data)
   );

   // job store: queue-major, ring slot within the queue
   assign st_addr = SAW'(cur_q_ff) * SAW'(QUEUE_DEPTH) + SAW'(HW'(alu_sum));

   wsq_ram #(
      .WIDTH   (IDW),
      .DEPTH   (SD)
   ) u_job_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_addr),
      .wr_data (job_ff),
      .rd_en   (st_rd_en),
      .rd_addr (st_addr),
      .rd_data (st_rd_data)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wsq_pkg::ST_IDLE;
         active_ff    <= wsq_pkg::ACTQ_RESET;
         pending_ff   <= '0;
         valid_ff     <= '0;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         pending_ff   <= pending_in;
         valid_ff     <= valid_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      cur_q_ff      <= cur_q_in;
      scan_cnt_ff   <= scan_cnt_in;
      job_ff        <= job_in;
      head_ff       <= head_in;
      fill_ff       <= fill_in;
      got_ff        <= got_in;
      from_ff       <= from_in;
      rsp_status_ff <= rsp_status_in;
      rsp_got_ff    <= rsp_got_in;
      rsp_from_ff   <= rsp_from_in;
      rsp_pend_ff   <= rsp_pend_in;
   end

endmodule

### src/wsq_checker.sv
// ----------------------------------------------------------------------------
// Work-stealing queue set: port checker
// Watches the request and response ports of the top level over time.
// ----------------------------------------------------------------------------
module wsq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [wsq_pkg::STATUS_W-1:0] rsp_status,
   input logic [wsq_pkg::JOB_W-1:0]    rsp_got_job,
   input logic [wsq_pkg::QIDX_W-1:0]   rsp_from_queue
);

   // a stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // reset empties the output register
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a failed request hands out no job
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != wsq_pkg::STATUS_OK |->
         rsp_got_job == '0 && rsp_from_queue == '0)
      else $error("failed request carries a job");

   // the sequencer is busy the cycle after a request is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accepting a request");

   // no response can appear the cycle after a request is taken
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response one cycle after request");

endmodule

bind work_stealing_queue_set_top wsq_checker u_wsq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_status     (rsp_if.status),
   .rsp_got_job    (rsp_if.got_job),
   .rsp_from_queue (rsp_if.from_queue)
);
